// ===== sv/lpsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsd_pkg: shared definitions for the length-prefixed stream deframer
// Field widths, default framing limits and the per-byte mark record.
// ----------------------------------------------------------------------------
package lpsd_pkg;

   localparam int BYTE_W   = 8;
   localparam int TAG_W    = 16;
   localparam int LEN_W    = 16;

   // Stream data word: byte in the low bits, session tag above it.
   localparam int DATA_W   = BYTE_W + TAG_W;

   // Result sideband bit positions.
   localparam int USER_FIRST = 0;
   localparam int USER_ERROR = 1;
   localparam int RSP_USER_W = 2;

   localparam int DEFAULT_HEADER_BYTES     = 4;
   localparam int DEFAULT_MAX_PACKET_BYTES = 4096;

   // Marks that the framer attaches to the byte being taken.
   typedef struct packed {
      logic first;
      logic last;
      logic error;
   } marks_type;

endpackage

// ===== sv/length_prefixed_stream_deframer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_stream_deframer_core: byte stream to packet deframer
// Cuts a byte stream into packets whose header opens with a little-endian
// total length, and marks each delivered byte with first, last and error.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  tdata (low bit up)               tuser                  tlast
//  -------  ---  -------------------------------  ---------------------  -----------
//  req_     in   stream_byte[7:0], session_tag    deliver                -
//  rsp_     out  packet_byte[7:0], owner_tag      first_of_packet, error last_of_packet
//
// One request is taken per cycle unless a result waits on a stalled output;
// its result appears in the output register in the next cycle. Throughput is
// set by the single framing state update per request. A request with deliver
// low advances the framing and gives no result. The output register is
// refilled in the same cycle it is drained, so a stall on the result side
// holds req_tready low only while a result is waiting. Reset is synchronous
// and active high; it clears the framing state and the output valid flag.
//
module length_prefixed_stream_deframer_core #(
   parameter int HEADER_BYTES     = lpsd_pkg::DEFAULT_HEADER_BYTES,
   parameter int MAX_PACKET_BYTES = lpsd_pkg::DEFAULT_MAX_PACKET_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] stream_byte, [23:8] session_tag
   input  logic [lpsd_pkg::DATA_W-1:0]     req_tdata,
   // [0] deliver
   input  logic                            req_tuser,

   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] packet_byte, [23:8] owner_tag
   output logic [lpsd_pkg::DATA_W-1:0]     rsp_tdata,
   // [0] first_of_packet, [1] length_error
   output logic [lpsd_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast
);
   import lpsd_pkg::*;

   logic                  req_take;
   marks_type             marks;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;
   logic                  rsp_last_ff, rsp_last_in;

   // The output register may be loaded whenever it is empty or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   lpsd_framer #(
      .HEADER_BYTES     (HEADER_BYTES),
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_framer (
      .clock     (clock),
      .reset     (reset),
      .step      (req_take),
      .data_byte (req_tdata[BYTE_W-1:0]),
      .marks     (marks)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (req_take) begin
         // Dropped bytes still advance framing but never reach the output.
         rsp_valid_in = req_tuser;
         rsp_data_in  = req_tdata;
         rsp_user_in  = '0;
         rsp_user_in[USER_FIRST] = marks.first;
         rsp_user_in[USER_ERROR] = marks.error;
         rsp_last_in  = marks.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   // The opening header byte can never also close its packet.
   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[USER_FIRST] && rsp_tlast))
      else $error("first and last marks on the same byte");

   // The length is unknown on the opening byte, so no error may show there.
   a_first_no_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[USER_FIRST]) |-> !rsp_tuser[USER_ERROR])
      else $error("length error flagged on the first header byte");

   // A delivered request always produces a result in the next cycle.
   a_deliver_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=> rsp_tvalid)
      else $error("delivered request lost");

   // Right after reset is released the output register is empty and requests
   // are taken.
   a_ready_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (req_tready && !rsp_tvalid))
      else $error("not ready after reset");
`endif

endmodule

// ===== sv/lpsd_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsd_framer: packet boundary tracker
// Holds the position inside the current packet and its decoded length, and
// gives the marks for the byte presented this cycle.
// ----------------------------------------------------------------------------
module lpsd_framer #(
   parameter int HEADER_BYTES     = lpsd_pkg::DEFAULT_HEADER_BYTES,
   parameter int MAX_PACKET_BYTES = lpsd_pkg::DEFAULT_MAX_PACKET_BYTES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [lpsd_pkg::BYTE_W-1:0] data_byte,
   output lpsd_pkg::marks_type         marks
);
   import lpsd_pkg::*;

   localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(HEADER_BYTES);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PACKET_BYTES);

   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  plen_ff, plen_in;
   logic [BYTE_W-1:0] low_ff, low_in;
   logic              err_ff, err_in;

   logic [LEN_W-1:0]  len_word;
   logic              len_bad;
   logic              is_first;
   logic              is_second;
   logic [LEN_W:0]    pos_next;

   always_comb begin
      is_first  = (pos_ff == '0);
      is_second = (pos_ff == LEN_W'(1));
      len_word  = {data_byte, low_ff};
      len_bad   = (len_word < HDR_LEN) || (len_word > MAX_LEN);
      pos_next  = {1'b0, pos_ff} + (LEN_W+1)'(1);

      low_in  = low_ff;
      plen_in = plen_ff;
      err_in  = err_ff;
      if (is_first) begin
         low_in = data_byte;
         err_in = 1'b0;
      end else if (is_second) begin
         // A bad length turns the packet into a header-only one.
         plen_in = len_bad ? HDR_LEN : len_word;
         err_in  = len_bad;
      end

      marks.first = is_first;
      marks.error = !is_first && err_in;
      marks.last  = !is_first && (pos_next >= {1'b0, plen_in});

      if (is_first) begin
         pos_in = LEN_W'(1);
      end else if (marks.last) begin
         pos_in = '0;
      end else begin
         pos_in = pos_next[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         plen_ff <= '0;
         low_ff  <= '0;
         err_ff  <= 1'b0;
      end else if (step) begin
         pos_ff  <= pos_in;
         plen_ff <= plen_in;
         low_ff  <= low_in;
         err_ff  <= err_in;
      end
   end

endmodule
